@@ hw/rtl/mctt_pkg.sv @@
// Shared types and constants for the MIDI clock tempo tracker.
package mctt_pkg;

    localparam int TS_W     = 63;   // timestamp width
    localparam int ST_W     = 8;    // status byte width
    localparam int TEMPO_W  = 25;   // Q9.16 tempo width
    localparam int NS_Q16_W = 52;   // width of one minute in ns, scaled by 2^16

    // 60e9 ns * 65536
    localparam logic [NS_Q16_W-1:0] NS_Q16 = 52'd3932160000000000;

    localparam int RING_DEPTH_DEF      = 48;
    localparam int PULSES_PER_BEAT_DEF = 24;

    localparam logic [TEMPO_W-1:0] MIN_BPM_RST = 25'd3276800;
    localparam logic [TEMPO_W-1:0] MAX_BPM_RST = 25'd16384000;

    localparam logic [ST_W-1:0] ST_CLOCK = 8'hF8;
    localparam logic [ST_W-1:0] ST_START = 8'hFA;
    localparam logic [ST_W-1:0] ST_STOP  = 8'hFC;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPM = 1'b1;

    // Stream widths, padded to whole bytes
    localparam int IN_W  = 72;
    localparam int OUT_W = 160;

    // Output tdata bit positions
    localparam int OB_ACC    = 0;
    localparam int OB_RUN    = 1;
    localparam int OB_BEAT   = 2;
    localparam int OB_TEMPO  = 3;
    localparam int OB_LAST   = OB_TEMPO + TEMPO_W;
    localparam int OB_SMOOTH = OB_LAST + TS_W;
    localparam int OB_END    = OB_SMOOTH + TS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SM_DIV,
        S_TP_PREP,
        S_TP_DIV,
        S_OUT
    } t_state;

endpackage

@@ hw/rtl/midi_clock_tempo_tracker_core.sv @@
// MIDI clock tempo tracker: timestamp ring memory, shared serial divider and control.
// Flow: start, stop and other bytes go from idle straight to the output state. A timing clock
// passes through prep, the beat-length division on a beat with a tempo held, tempo prep and the
// tempo division if the span allows, both on the restoring divider, one quotient bit per cycle.
// Throughput: one item at a time; the next is taken once the result is in the output register.
// Reset: synchronous, active low; clears control, tempo and beat state; the ring is not cleared.
module midi_clock_tempo_tracker_core #(
    parameter int RING_DEPTH      = mctt_pkg::RING_DEPTH_DEF,
    parameter int PULSES_PER_BEAT = mctt_pkg::PULSES_PER_BEAT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // status_byte [7:0], timestamp_ns [70:8], zero [71]
    input  logic [mctt_pkg::IN_W-1:0]      i_s_tdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // accepted [0], running [1], beat_mark [2], tempo_q16 [27:3],
    // latest_beat_ns [90:28], smoothed_beat_ns [153:91], zero [159:154]
    output logic [mctt_pkg::OUT_W-1:0]     o_m_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mctt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mctt_pkg::TEMPO_W-1:0]   i_cfg_data
);
    import mctt_pkg::*;

    localparam int WI_W   = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int PH_W   = $clog2(PULSES_PER_BEAT + 1);
    localparam int DVD_W  = NS_Q16_W + WI_W;
    localparam int DVS_W  = TS_W + PH_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    t_state r_state, n_state;

    logic                r_run;
    logic [WI_W-1:0]     r_wi;
    logic [FILL_W-1:0]   r_fill;
    logic [PH_W-1:0]     r_phase;
    logic [TEMPO_W-1:0]  r_tempo;
    logic [TS_W-1:0]     r_beat_time;
    logic [TS_W-1:0]     r_smooth;
    logic [TEMPO_W-1:0]  r_min;
    logic [TEMPO_W-1:0]  r_max;

    logic [TS_W-1:0]     r_mem [RING_DEPTH];
    logic [TS_W-1:0]     r_early;

    logic                r_acc;
    logic                r_beat;
    logic [TS_W-1:0]     r_ts;
    logic [TS_W-1:0]     r_span;
    logic                r_span_ok;

    logic [DVS_W-1:0]    r_rem;
    logic [DVD_W-1:0]    r_quo;
    logic [DVS_W-1:0]    r_dvs;
    logic [CNT_W-1:0]    r_cnt;

    logic                r_ov;
    logic [OUT_W-1:0]    r_odata;

    logic [ST_W-1:0]     w_status;
    logic [TS_W-1:0]     w_ts;
    logic                w_in_acc;
    logic [WI_W-1:0]     w_wi_base, w_wi_next, w_rd_addr;
    logic [FILL_W-1:0]   w_fill_base, w_fill_next;
    logic [PH_W-1:0]     w_ph_base, w_ph_next;
    logic                w_beat;
    logic [DVS_W:0]      w_shift;
    logic                w_ge;
    logic [DVD_W-1:0]    w_quo_next;
    logic                w_div_last;
    logic                w_need_sm;
    logic [DVD_W-1:0]    w_num;
    logic [DVS_W-1:0]    w_den;
    logic                w_out_load;

    assign w_status = i_s_tdata[ST_W-1:0];
    assign w_ts     = i_s_tdata[ST_W+TS_W-1:ST_W];
    assign w_in_acc = i_s_tvalid && o_s_tready;

    // A clock while stopped arms first: index, fill and phase restart from zero
    assign w_wi_base   = r_run ? r_wi : '0;
    assign w_fill_base = r_run ? r_fill : '0;
    assign w_ph_base   = r_run ? r_phase : '0;
    assign w_wi_next   = (w_wi_base == WI_W'(RING_DEPTH - 1)) ? '0 : w_wi_base + 1'b1;
    assign w_fill_next = (w_fill_base == FILL_W'(RING_DEPTH)) ? w_fill_base
                                                              : w_fill_base + 1'b1;
    // phase is write index mod pulses per beat, restarted when the index wraps
    assign w_ph_next   = (w_wi_next == '0) ? '0 :
                         (w_ph_base == PH_W'(PULSES_PER_BEAT - 1)) ? '0 : w_ph_base + 1'b1;
    assign w_beat      = (w_ph_next == '0);
    // Oldest pulse: entry 0 until the ring is full, then the entry about to be overwritten.
    // Never equal to the write address whenever the tempo is computed.
    assign w_rd_addr   = (w_fill_next == FILL_W'(RING_DEPTH)) ? w_wi_next : '0;

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_status == ST_CLOCK) begin
            r_mem[w_wi_base] <= w_ts;
            r_early          <= r_mem[w_rd_addr];
        end
    end

    // restoring divider step
    assign w_shift    = {r_rem, r_quo[DVD_W-1]};
    assign w_ge       = (w_shift >= {1'b0, r_dvs});
    assign w_quo_next = {r_quo[DVD_W-2:0], w_ge};
    assign w_div_last = (r_cnt == CNT_W'(1));

    assign w_need_sm = r_beat && (r_tempo != '0) && (r_beat_time != '0);
    // floor(floor(a/b)/c) == floor(a/(b*c)), so one division gives the tempo
    assign w_num = DVD_W'(r_fill - 1'b1) * DVD_W'(NS_Q16);
    assign w_den = DVS_W'(r_span) * DVS_W'(PULSES_PER_BEAT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = (w_status == ST_CLOCK) ? S_PREP : S_OUT;
                end
            end
            S_PREP: begin
                n_state = w_need_sm ? S_SM_DIV : S_TP_PREP;
            end
            S_SM_DIV: begin
                if (w_div_last) begin
                    n_state = S_TP_PREP;
                end
            end
            S_TP_PREP: begin
                n_state = (r_fill > FILL_W'(2) && r_span_ok) ? S_TP_DIV : S_OUT;
            end
            S_TP_DIV: begin
                if (w_div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_wi        <= '0;
            r_fill      <= '0;
            r_phase     <= '0;
            r_tempo     <= '0;
            r_beat_time <= '0;
            r_smooth    <= '0;
            r_min       <= MIN_BPM_RST;
            r_max       <= MAX_BPM_RST;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_BPM: r_min <= i_cfg_data;
                    CFG_MAX_BPM: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        case (w_status)
                            ST_START: begin
                                r_run   <= 1'b1;
                                r_wi    <= '0;
                                r_fill  <= '0;
                                r_phase <= '0;
                            end
                            ST_STOP: begin
                                r_run <= 1'b0;
                            end
                            ST_CLOCK: begin
                                r_run   <= 1'b1;
                                r_wi    <= w_wi_next;
                                r_fill  <= w_fill_next;
                                r_phase <= w_ph_next;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PREP: begin
                    if (r_beat && !w_need_sm) begin
                        r_smooth    <= r_ts;
                        r_beat_time <= r_ts;
                    end
                end
                S_SM_DIV: begin
                    if (w_div_last) begin
                        r_smooth    <= r_beat_time + TS_W'(w_quo_next);
                        r_beat_time <= r_ts;
                    end
                end
                S_TP_PREP: begin
                    if (r_fill > FILL_W'(2) && !r_span_ok) begin
                        r_tempo <= '0;
                    end
                end
                S_TP_DIV: begin
                    if (w_div_last) begin
                        if (w_quo_next < DVD_W'(r_min) || w_quo_next > DVD_W'(r_max)) begin
                            r_tempo <= '0;
                        end else begin
                            r_tempo <= w_quo_next[TEMPO_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // item payload and divider datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    r_ts   <= w_ts;
                    r_acc  <= (w_status == ST_CLOCK) || (w_status == ST_START) ||
                              (w_status == ST_STOP);
                    r_beat <= (w_status == ST_CLOCK) && w_beat;
                end
            end
            S_PREP: begin
                r_span    <= r_ts - r_early;
                r_span_ok <= (r_ts > r_early);
                r_rem     <= '0;
                r_quo     <= DVD_W'(NS_Q16);
                r_dvs     <= DVS_W'(r_tempo);
                r_cnt     <= CNT_W'(DVD_W);
            end
            S_TP_PREP: begin
                r_rem <= '0;
                r_quo <= w_num;
                r_dvs <= w_den;
                r_cnt <= CNT_W'(DVD_W);
            end
            S_SM_DIV, S_TP_DIV: begin
                r_rem <= w_ge ? DVS_W'(w_shift - {1'b0, r_dvs}) : w_shift[DVS_W-1:0];
                r_quo <= w_quo_next;
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_odata <= {{(OUT_W-OB_END){1'b0}}, r_smooth, r_beat_time, r_tempo,
                        r_beat, r_run, r_acc};
        end
    end

    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = r_odata;
    assign o_cfg_ready = 1'b1;

endmodule

@@ hw/rtl/mctt_checker.sv @@
// Port-level assertions for the tempo tracker, bound to the top level.
module mctt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [mctt_pkg::OUT_W-1:0] o_m_tdata
);
    import mctt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one item in flight: ready drops after each input transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while one is in flight");

    // a beat only comes from an accepted clock, which leaves the tracker running
    a_beat_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[OB_BEAT] |-> o_m_tdata[OB_ACC] && o_m_tdata[OB_RUN])
        else $error("beat mark without a running clock");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset did not clear the output");

endmodule

bind midi_clock_tempo_tracker_core mctt_checker u_mctt_checker (.*);

@@ bench/midi_clock_tempo_tracker_core_tb.sv @@
// Self-checking bench for the MIDI clock tempo tracker: predicted reports against the stream output.
module midi_clock_tempo_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mctt_pkg::*;

    localparam int RING = RING_DEPTH_DEF;
    localparam int PPB  = PULSES_PER_BEAT_DEF;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam logic [TS_W-1:0] TS_MAX = '1;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 175;

    typedef struct packed {
        logic               accepted;
        logic               running;
        logic               beat_mark;
        logic [TEMPO_W-1:0] tempo;
        logic [TS_W-1:0]    beat_stamp;
        logic [TS_W-1:0]    smoothed;
    } t_tempo_report;

    class t_tempo_scoreboard;
        bit                 run_flag;
        bit [TS_W-1:0]      ring [RING];
        int unsigned        wr_pos;
        int unsigned        fill;
        bit [TEMPO_W-1:0]   tempo;
        bit [TEMPO_W-1:0]   min_bpm;
        bit [TEMPO_W-1:0]   max_bpm;
        bit [TS_W-1:0]      beat_ns;
        bit [TS_W-1:0]      smooth_ns;
        t_tempo_report      expected_reports [$];
        int                 errors;
        int                 n_checked;
        int                 n_beats;
        int                 n_tempo;
        int                 n_ignored;

        function new();
            min_bpm = MIN_BPM_RST;
            max_bpm = MAX_BPM_RST;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TEMPO_W-1:0] val);
            if (idx == CFG_MIN_BPM) begin
                min_bpm = val;
            end else if (idx == CFG_MAX_BPM) begin
                max_bpm = val;
            end
        endfunction

        function void rearm();
            run_flag = 1'b1;
            fill     = 0;
            wr_pos   = 0;
        endfunction

        function bit [TEMPO_W-1:0] tempo_of_span(bit [TS_W-1:0] early, bit [TS_W-1:0] late,
                                                 int unsigned count);
            bit [63:0] span;
            bit [63:0] num;
            bit [63:0] q;
            if (count < 2 || late <= early) return '0;
            span = 64'(late - early);
            num  = 64'(count - 1) * 64'(NS_Q16);
            q    = (num / 64'(PPB)) / span;
            if (q < 64'(min_bpm) || q > 64'(max_bpm)) return '0;
            return q[TEMPO_W-1:0];
        endfunction

        function bit clock_pulse(bit [TS_W-1:0] ts);
            bit            beat;
            bit [63:0]     beat_len;
            bit [TS_W-1:0] early;
            if (!run_flag) rearm();
            ring[wr_pos] = ts;
            wr_pos = (wr_pos + 1) % RING;
            if (fill < RING) fill++;
            beat = (wr_pos % PPB) == 0;
            if (beat) begin
                // prediction uses the tempo held before this pulse
                if (tempo != 0 && beat_ns != 0) begin
                    beat_len  = 64'(NS_Q16) / 64'(tempo);
                    smooth_ns = beat_ns + beat_len[TS_W-1:0];
                end else begin
                    smooth_ns = ts;
                end
                beat_ns = ts;
            end
            if (fill > 2) begin
                early = (fill < RING) ? ring[0] : ring[wr_pos];
                tempo = tempo_of_span(early, ts, fill);
            end
            return beat;
        endfunction

        function void note_byte(logic [ST_W-1:0] status, logic [TS_W-1:0] ts);
            t_tempo_report r;
            r.accepted  = 1'b1;
            r.beat_mark = 1'b0;
            case (status)
                ST_START: rearm();
                ST_STOP:  run_flag = 1'b0;
                ST_CLOCK: r.beat_mark = clock_pulse(ts);
                default:  r.accepted = 1'b0;
            endcase
            r.running    = run_flag;
            r.tempo      = tempo;
            r.beat_stamp = beat_ns;
            r.smoothed   = smooth_ns;
            if (!r.accepted) n_ignored++;
            if (r.beat_mark) n_beats++;
            if (r.tempo != 0) n_tempo++;
            expected_reports.push_back(r);
        endfunction

        function void cmp_field(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
            end
        endfunction

        function void check_report(logic [OUT_W-1:0] d);
            t_tempo_report e;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected report, expected none, got %0h", $time, d);
                return;
            end
            e = expected_reports.pop_front();
            n_checked++;
            cmp_field("accepted",   64'(e.accepted),   64'(d[OB_ACC]));
            cmp_field("running",    64'(e.running),    64'(d[OB_RUN]));
            cmp_field("beat_mark",  64'(e.beat_mark),  64'(d[OB_BEAT]));
            cmp_field("tempo_q16",  64'(e.tempo),      64'(d[OB_TEMPO +: TEMPO_W]));
            cmp_field("beat_stamp", 64'(e.beat_stamp), 64'(d[OB_LAST +: TS_W]));
            cmp_field("smoothed",   64'(e.smoothed),   64'(d[OB_SMOOTH +: TS_W]));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic [IN_W-1:0]      i_s_tdata = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TEMPO_W-1:0]   i_cfg_data = '0;

    t_tempo_scoreboard sb = new();

    bit          idle_on = 1'b1;
    int          stim_count = 0;
    int          cfg_writes = 0;
    int          hold_left = 0;
    bit          long_hold_done = 1'b0;
    int unsigned cycle_count = 0;

    midi_clock_tempo_tracker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random back-pressure bursts, plus one long hold-off once traffic is flowing
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!long_hold_done && sb.n_checked >= 400) begin
            long_hold_done <= 1'b1;
            hold_left      <= 600;
            i_m_tready     <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_left  <= $urandom_range(0, 17);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_report(o_m_tdata);
    end

    task automatic send_byte(input logic [ST_W-1:0] status, input logic [TS_W-1:0] ts);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= {1'b0, ts, status};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(status, ts);
        stim_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TEMPO_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_register(idx, val);
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // Drop valid and let every outstanding report come back before touching registers
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic directed_bytes();
        send_byte(8'h00, '0);                          // ignored, all zeros
        send_byte(8'hFF, TS_MAX);                      // ignored, all ones
        send_byte(8'hFB, 63'($urandom));               // continue is not handled
        send_byte(ST_STOP, 63'($urandom));             // stop while already stopped
        send_byte(ST_CLOCK, 63'd1000);                 // clock while stopped arms the tracker
        send_byte(ST_CLOCK, 63'd20834333);
        send_byte(ST_CLOCK, 63'd41667666);             // third pulse gives 120 bpm
        send_byte(8'hF9, 63'($urandom));
        send_byte(ST_STOP, 63'd50000000);
        send_byte(ST_START, 63'd60000000);
        send_byte(ST_CLOCK, 63'd5000);                 // equal stamps: zero span
        send_byte(ST_CLOCK, 63'd5000);
        send_byte(ST_CLOCK, 63'd5000);
        send_byte(ST_CLOCK, 63'd4000);                 // going backwards: negative span
        send_byte(ST_START, '0);
        send_byte(ST_CLOCK, 63'd0);                    // far too fast
        send_byte(ST_CLOCK, 63'd1);
        send_byte(ST_CLOCK, 63'd2);
        send_byte(ST_START, '0);
        send_byte(ST_CLOCK, 63'd0);                    // far too slow
        send_byte(ST_CLOCK, 63'd1000000000);
        send_byte(ST_CLOCK, 63'd2000000000);
        send_byte(ST_STOP, TS_MAX);
        send_byte(8'h90, 63'($urandom));
    endtask

    // 120 bpm placed so the second beat's prediction runs past the top of the timestamp range
    task automatic wrap_run();
        logic [TS_W-1:0] stride;
        logic [TS_W-1:0] base;
        stride = 63'd20833333;
        base   = TS_MAX - 63'd47 * stride - 63'd3;
        send_byte(ST_START, '0);
        for (int k = 0; k < 50; k++) send_byte(ST_CLOCK, base + 63'(k) * stride);
    endtask

    task automatic play_random_run(input bit last_phase);
        int              n;
        int              r;
        int unsigned     bpm;
        int unsigned     jit_max;
        logic [TS_W-1:0] stride;
        logic [TS_W-1:0] base;
        logic [TS_W-1:0] ts;
        if (!last_phase) idle_on = ($urandom_range(0, 3) != 0);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(48, 110) : $urandom_range(3, 60);
        r = $urandom_range(0, 19);
        if (r < 17) begin
            bpm    = $urandom_range(30, 320);
            stride = 63'(64'd2500000000 / 64'(bpm));
        end else if (r < 19) begin
            stride = 63'($urandom_range(0, 2000));
        end else begin
            stride = 63'({$urandom, $urandom} >> 20);
        end
        r = $urandom_range(0, 19);
        if (r < 12) begin
            base = 63'({$urandom, $urandom});
        end else if (r < 15) begin
            base = 63'($urandom);
        end else begin
            base = TS_MAX - 63'($urandom_range(0, 80)) * stride;
        end
        jit_max = (stride < 63'd4000000000) ? 32'(stride / 32) : 32'd1000;
        if ($urandom_range(0, 9) < 7) send_byte(ST_START, 63'({$urandom, $urandom}));
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_byte(8'($urandom), 63'({$urandom, $urandom}));
            end else if (r < 10) begin
                send_byte(ST_STOP, 63'({$urandom, $urandom}));
            end else if (r < 13) begin
                send_byte(ST_CLOCK, 63'({$urandom, $urandom}));
            end
            ts = base + 63'(k) * stride + 63'($urandom_range(0, jit_max));
            send_byte(ST_CLOCK, ts);
        end
        if ($urandom_range(0, 9) < 4) send_byte(ST_STOP, 63'({$urandom, $urandom}));
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d reports outstanding", $time, sb.pending());
        $display("midi_clock_tempo_tracker_core_tb: done, errors");
        $finish;
    end

    initial begin
        logic [TEMPO_W-1:0] lo;
        logic [TEMPO_W-1:0] hi;
        int                 target;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin lo = '0;           hi = '1;           end
                2: begin lo = 25'd6553600;  hi = 25'd9175040;  end  // 100..140 bpm
                3: begin lo = 25'd13107200; hi = 25'd3932160;  end  // min above max
                4: begin
                    lo = 25'($urandom_range(0, 7864320));
                    hi = 25'($urandom_range(9830400, 33554431));
                end
                default: begin lo = MIN_BPM_RST; hi = MAX_BPM_RST; end
            endcase
            write_register(CFG_MIN_BPM, lo);
            write_register(CFG_MAX_BPM, hi);
            if (phase == 0) begin
                directed_bytes();
                wrap_run();
            end
            // final stretch runs flat out on both sides
            if (phase == PHASES - 1) idle_on = 1'b0;
            target = stim_count + ITEMS_PER_PHASE;
            while (stim_count < target) play_random_run(phase == PHASES - 1);
            settle();
        end
        $display("tempo tracker: %0d reports checked, %0d ignored bytes, %0d beats, %0d locked",
                 sb.n_checked, sb.n_ignored, sb.n_beats, sb.n_tempo);
        $display("tempo tracker: %0d register writes across %0d range settings, errors %0d",
                 cfg_writes, PHASES, sb.errors);
        if (sb.errors == 0) begin
            $display("midi_clock_tempo_tracker_core_tb: done, clean");
        end else begin
            $display("midi_clock_tempo_tracker_core_tb: done, errors");
        end
        $finish;
    end

endmodule
